[rtl/gcsd_pkg.sv]
// Shared types and constants of the glyph cell stream decoder.
package gcsd_pkg;

    localparam int MAX_ROWS  = 12;
    localparam int MAX_WIDTH = 30;

    // Byte codes
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_SHADE_LO = 8'hDB;
    localparam logic [7:0] CH_SHADE_HI = 8'hDF;

    // Cell colors
    localparam logic [3:0] FG_BLOCK = 4'd7;
    localparam logic [3:0] FG_WHITE = 4'hF;
    localparam logic [3:0] FG_NONE  = 4'h0;
    localparam logic [2:0] BG_BLOCK = 3'd0;

    // Font kinds
    localparam logic [1:0] FONT_BLOCK = 2'd1;
    localparam logic [1:0] FONT_COLOR = 2'd2;

    typedef enum logic [0:0] {
        REG_FONT_KIND  = 1'b0,
        REG_BYTE_LIMIT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_ERROR  = 2'd2
    } t_out_kind;

    typedef enum logic [2:0] {
        PH_WIDTH     = 3'd0,
        PH_HEIGHT    = 3'd1,
        PH_CHAR      = 3'd2,
        PH_CHAR_WRAP = 3'd3,
        PH_ATTR      = 3'd4,
        PH_DONE      = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HDR_W,
        OP_HDR_H,
        OP_WIDEN,
        OP_PAD_CELL,
        OP_FINISH,
        OP_ERROR,
        OP_SUPP_CELL,
        OP_BLOCK_CHAR,
        OP_COLOR_CHAR,
        OP_ATTR
    } t_dp_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_PAD,
        S_BLOCK
    } t_ctl_state;

    typedef struct packed {
        t_phase phase;
        logic   end_hit;     // NUL byte or byte limit reached
        logic   kind_block;
        logic   kind_color;
        logic   wrap_fail;   // starting the next row would overflow
        logic   suppressing;
        logic   supp_last;   // padding cell about to go out ends the transaction
        logic   need_pad;
        logic   out_free;
    } t_dp_status;

endpackage

[rtl/glyph_cell_stream_decoder.sv]
// Top level of the glyph cell stream decoder: controller plus datapath.
// Path: a byte is held in the byte register, then S_DECODE writes any result to the output
//   register; block-mode body bytes go on to S_BLOCK and the glyph-end byte (NUL or byte
//   limit) to S_PAD, which write the results. Each padding cell (after CR or at glyph end)
//   is a result of its own. A new byte is taken only in S_IDLE, once the last is through.
//   The emit path gives one result per cycle while the 1-deep output register is free.
// Reset: synchronous, active low; resets the sequencer, glyph phase, config and output valid.
module glyph_cell_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_glyph_start,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_cell_char,
    output logic [3:0]  o_cell_fg,
    output logic [2:0]  o_cell_bg,
    output logic [3:0]  o_cell_row,
    output logic [7:0]  o_final_width,
    output logic [4:0]  o_rows_found,
    output logic        o_last
);
    import gcsd_pkg::*;

    // Command from sequencer, status back from datapath.
    t_dp_op     w_op;
    t_dp_status w_status;

    // The sequencer takes one byte transaction at a time, then walks the datapath
    // through header checks, slot handling and runs of padding cells. Each step that
    // produces a result waits until the output register is free, so a stalled
    // consumer simply holds the sequence in place.
    gcsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_op       (w_op)
    );

    // The datapath keeps glyph state (width, column, row, cells in row, CR
    // suppression, held char, byte count) and the registered result with its
    // last flag, which is resolved by lookahead when a padding run ends.
    gcsd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_glyph_start (i_glyph_start),
        .i_op          (w_op),
        .i_out_ready   (i_out_ready),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_cell_char   (o_cell_char),
        .o_cell_fg     (o_cell_fg),
        .o_cell_bg     (o_cell_bg),
        .o_cell_row    (o_cell_row),
        .o_final_width (o_final_width),
        .o_rows_found  (o_rows_found),
        .o_last        (o_last)
    );

endmodule

[rtl/gcsd_ctrl.sv]
// Sequencing state machine of the glyph cell stream decoder.
module gcsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  gcsd_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output gcsd_pkg::t_dp_op      o_op
);
    import gcsd_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                    unique case (i_status.phase)
                        PH_WIDTH:  o_op = OP_HDR_W;
                        PH_HEIGHT: o_op = OP_HDR_H;
                        PH_ATTR:   o_op = OP_ATTR;
                        PH_CHAR, PH_CHAR_WRAP: begin
                            priority if (i_status.end_hit) begin
                                o_op    = OP_WIDEN;
                                n_state = S_PAD;
                            end else if (!i_status.kind_block && !i_status.kind_color) begin
                                o_op = OP_ERROR;
                            end else if (i_status.kind_color) begin
                                o_op = i_status.wrap_fail ? OP_ERROR : OP_COLOR_CHAR;
                            end else begin
                                n_state = S_BLOCK;
                            end
                        end
                        default: o_op = OP_NONE;
                    endcase
                end
            end
            S_PAD: begin
                if (i_status.out_free) begin
                    if (i_status.need_pad) begin
                        o_op = OP_PAD_CELL;
                    end else begin
                        o_op    = OP_FINISH;
                        n_state = S_IDLE;
                    end
                end
            end
            S_BLOCK: begin
                if (i_status.out_free) begin
                    priority if (i_status.wrap_fail) begin
                        o_op    = OP_ERROR;
                        n_state = S_IDLE;
                    end else if (i_status.suppressing) begin
                        o_op = OP_SUPP_CELL;
                    end else begin
                        o_op    = OP_BLOCK_CHAR;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/gcsd_dp.sv]
// Datapath of the glyph cell stream decoder: glyph state, config and result register.
module gcsd_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_glyph_start,
    input  gcsd_pkg::t_dp_op      i_op,
    input  logic                  i_out_ready,
    output gcsd_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_cell_char,
    output logic [3:0]            o_cell_fg,
    output logic [2:0]            o_cell_bg,
    output logic [3:0]            o_cell_row,
    output logic [7:0]            o_final_width,
    output logic [4:0]            o_rows_found,
    output logic                  o_last
);
    import gcsd_pkg::*;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Control state
    logic [1:0]  r_font_kind;
    logic [15:0] r_byte_limit;
    t_phase      r_phase, n_phase;
    logic        r_out_valid, n_out_valid;
    // Glyph state and payload
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_width, n_width;
    logic [7:0]  r_col, n_col;
    logic [3:0]  r_row, n_row;
    logic [7:0]  r_cells, n_cells;
    logic        r_supp, n_supp;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_bytes, n_bytes;
    t_out_kind   r_kind, n_kind;
    logic [7:0]  r_char, n_char;
    logic [3:0]  r_fg, n_fg;
    logic [2:0]  r_bg, n_bg;
    logic [3:0]  r_crow, n_crow;
    logic [7:0]  r_fw, n_fw;
    logic [4:0]  r_rf, n_rf;
    logic        r_last, n_last;

    logic        w_wrap;
    logic [3:0]  w_row_after;
    logic [7:0]  w_cells_after;
    logic        w_wrap_fail;
    logic [7:0]  w_col_inc;
    logic        w_wraps;
    logic        w_print;
    logic        w_is_cr;
    logic [16:0] w_sum1, w_sum2;
    logic [15:0] w_bytes_inc1, w_bytes_inc2;
    logic [3:0]  w_fg_raw, w_fg_fix, w_fg_attr;
    logic        w_shade;
    logic        w_supp_last;
    logic        w_out_free;
    logic        w_emit;
    logic        w_bad;

    assign w_wrap        = (r_phase == PH_CHAR_WRAP);
    assign w_row_after   = w_wrap ? r_row + 4'd1 : r_row;
    assign w_cells_after = w_wrap ? 8'd0 : r_cells;
    assign w_wrap_fail   = w_wrap && (({1'b0, r_row} + 5'd1) >= 5'(MAX_ROWS));
    assign w_col_inc     = r_col + 8'd1;
    assign w_wraps       = (w_col_inc > r_width);
    assign w_print       = (r_byte >= CH_SPACE);
    assign w_is_cr       = (r_byte == CH_CR);
    assign w_sum1        = {1'b0, r_bytes} + 17'd1;
    assign w_sum2        = {1'b0, r_bytes} + 17'd2;
    assign w_bytes_inc1  = w_sum1[16] ? 16'hFFFF : w_sum1[15:0];
    assign w_bytes_inc2  = w_sum2[16] ? 16'hFFFF : w_sum2[15:0];
    assign w_fg_raw      = r_byte[3:0];
    assign w_fg_fix      = (w_fg_raw == FG_WHITE) ? FG_NONE : w_fg_raw;
    assign w_shade       = (r_held >= CH_SHADE_LO) && (r_held <= CH_SHADE_HI);
    assign w_fg_attr     = (w_shade && (w_fg_fix == FG_NONE)) ? FG_WHITE : w_fg_fix;
    // The padding cell closes the transaction when the row wraps and nothing follows.
    assign w_supp_last   = w_wraps && !w_print
                           && !(({1'b0, w_row_after} + 5'd1) >= 5'(MAX_ROWS));
    assign w_out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.phase       = r_phase;
        o_status.end_hit     = (r_byte == CH_NUL) || (r_bytes >= r_byte_limit);
        o_status.kind_block  = (r_font_kind == FONT_BLOCK);
        o_status.kind_color  = (r_font_kind == FONT_COLOR);
        o_status.wrap_fail   = w_wrap_fail;
        o_status.suppressing = r_supp;
        o_status.supp_last   = w_supp_last;
        o_status.need_pad    = (r_cells < r_width);
        o_status.out_free    = w_out_free;
    end

    always_comb begin
        n_phase = r_phase;
        n_byte  = r_byte;
        n_width = r_width;
        n_col   = r_col;
        n_row   = r_row;
        n_cells = r_cells;
        n_supp  = r_supp;
        n_held  = r_held;
        n_bytes = r_bytes;
        w_emit  = 1'b0;
        w_bad   = 1'b0;
        n_kind  = KIND_CELL;
        n_char  = 8'd0;
        n_fg    = 4'd0;
        n_bg    = 3'd0;
        n_crow  = 4'd0;
        n_fw    = 8'd0;
        n_rf    = 5'd0;
        n_last  = 1'b1;
        unique case (i_op)
            OP_LOAD: begin
                n_byte = i_data_byte;
                if (i_glyph_start) begin
                    n_phase = PH_WIDTH;
                end
            end
            OP_HDR_W: begin
                w_bad   = (r_byte == CH_NUL) || (r_byte > 8'(MAX_WIDTH));
                n_width = r_byte;
                n_col   = 8'd0;
                n_row   = 4'd0;
                n_cells = 8'd0;
                n_supp  = 1'b0;
                n_held  = 8'd0;
                n_bytes = 16'd0;
                n_phase = w_bad ? PH_DONE : PH_HEIGHT;
                w_emit  = w_bad;
                n_kind  = KIND_ERROR;
            end
            OP_HDR_H: begin
                w_bad   = (r_byte == CH_NUL) || (r_byte > 8'(MAX_ROWS));
                n_phase = w_bad ? PH_DONE : PH_CHAR;
                w_emit  = w_bad;
                n_kind  = KIND_ERROR;
            end
            OP_WIDEN: begin
                if (r_cells > r_width) begin
                    n_width = r_cells;
                end
            end
            OP_PAD_CELL: begin
                w_emit  = 1'b1;
                n_char  = CH_SPACE;
                n_fg    = FG_BLOCK;
                n_bg    = BG_BLOCK;
                n_crow  = r_row;
                n_last  = 1'b0;
                n_cells = sat_inc8(r_cells);
            end
            OP_FINISH: begin
                w_emit  = 1'b1;
                n_kind  = KIND_FINISH;
                n_fw    = r_width;
                n_rf    = {1'b0, r_row} + 5'd2 + {4'd0, w_wrap};
                n_phase = PH_DONE;
            end
            OP_ERROR: begin
                w_emit  = 1'b1;
                n_kind  = KIND_ERROR;
                n_phase = PH_DONE;
            end
            OP_SUPP_CELL: begin
                w_emit  = 1'b1;
                n_char  = CH_SPACE;
                n_fg    = FG_BLOCK;
                n_bg    = BG_BLOCK;
                n_crow  = w_row_after;
                n_last  = w_supp_last;
                n_row   = w_row_after;
                n_cells = sat_inc8(w_cells_after);
                n_col   = w_wraps ? 8'd0 : w_col_inc;
                n_supp  = w_wraps ? 1'b0 : r_supp;
                n_phase = w_wraps ? PH_CHAR_WRAP : PH_CHAR;
            end
            OP_BLOCK_CHAR: begin
                w_emit  = w_print;
                n_char  = r_byte;
                n_fg    = FG_BLOCK;
                n_bg    = BG_BLOCK;
                n_crow  = w_row_after;
                n_row   = w_row_after;
                n_cells = w_print ? sat_inc8(w_cells_after) : w_cells_after;
                n_col   = w_wraps ? 8'd0 : w_col_inc;
                n_supp  = w_wraps ? 1'b0 : (w_is_cr || r_supp);
                n_phase = w_wraps ? PH_CHAR_WRAP : PH_CHAR;
                n_bytes = w_bytes_inc1;
            end
            OP_COLOR_CHAR: begin
                n_row   = w_row_after;
                n_cells = w_cells_after;
                if (w_print) begin
                    n_held  = r_byte;
                    n_phase = PH_ATTR;
                end else begin
                    n_col   = w_wraps ? 8'd0 : w_col_inc;
                    n_supp  = w_wraps ? 1'b0 : (w_is_cr || r_supp);
                    n_phase = w_wraps ? PH_CHAR_WRAP : PH_CHAR;
                    n_bytes = w_bytes_inc1;
                end
            end
            OP_ATTR: begin
                w_emit  = !r_supp;
                n_char  = r_held;
                n_fg    = w_fg_attr;
                n_bg    = r_byte[6:4];
                n_crow  = r_row;
                n_cells = r_supp ? r_cells : sat_inc8(r_cells);
                n_col   = w_wraps ? 8'd0 : w_col_inc;
                n_supp  = w_wraps ? 1'b0 : r_supp;
                n_phase = w_wraps ? PH_CHAR_WRAP : PH_CHAR;
                n_bytes = w_bytes_inc2;
            end
            default: n_phase = r_phase;
        endcase
        n_out_valid = w_emit || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_kind  <= FONT_BLOCK;
            r_byte_limit <= 16'hFFFF;
            r_phase      <= PH_WIDTH;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FONT_KIND) begin
                    r_font_kind <= i_cfg_data[1:0];
                end else begin
                    r_byte_limit <= i_cfg_data;
                end
            end
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_width <= n_width;
        r_col   <= n_col;
        r_row   <= n_row;
        r_cells <= n_cells;
        r_supp  <= n_supp;
        r_held  <= n_held;
        r_bytes <= n_bytes;
        if (w_emit) begin
            r_kind <= n_kind;
            r_char <= n_char;
            r_fg   <= n_fg;
            r_bg   <= n_bg;
            r_crow <= n_crow;
            r_fw   <= n_fw;
            r_rf   <= n_rf;
            r_last <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_cell_char   = r_char;
    assign o_cell_fg     = r_fg;
    assign o_cell_bg     = r_bg;
    assign o_cell_row    = r_crow;
    assign o_final_width = r_fw;
    assign o_rows_found  = r_rf;
    assign o_last        = r_last;

endmodule

[rtl/gcsd_checker.sv]
// Port-level assertions of the glyph cell stream decoder and their bind.
module gcsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_index,
    input logic [15:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_glyph_start,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_cell_char,
    input logic [3:0]  o_cell_fg,
    input logic [2:0]  o_cell_bg,
    input logic [3:0]  o_cell_row,
    input logic [7:0]  o_final_width,
    input logic [4:0]  o_rows_found,
    input logic        o_last
);
    import gcsd_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_kind)
            && $stable(o_cell_char) && $stable(o_last) && $stable(o_final_width)))
        else $error("result changed while stalled");

    // One byte transaction in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous byte still decoding");

    // Finish and error results close the transaction.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != KIND_CELL)) |-> o_last)
        else $error("finish or error result without last");

    // Non-cell results carry zero cell fields; cell results carry no summary.
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == KIND_CELL)
            ? (o_final_width == 8'd0 && o_rows_found == 5'd0)
            : (o_cell_char == 8'd0 && o_cell_fg == 4'd0 && o_cell_bg == 3'd0
               && o_cell_row == 4'd0)))
        else $error("result fields inconsistent with kind");

endmodule

bind glyph_cell_stream_decoder gcsd_checker u_gcsd_checker (.*);
